### hw/rtl/bouncing_square_test_pattern_top_defines.svh
// Assertion helpers used by the datapath RTL. They expect clk and rst in scope.
`ifndef BOUNCING_SQUARE_TEST_PATTERN_TOP_DEFINES_SVH
`define BOUNCING_SQUARE_TEST_PATTERN_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BSQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsq assertion failed");

// Next-cycle implication, disabled during reset
`define BSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsq assertion failed");

`endif

### hw/rtl/bsq_pkg.sv
`timescale 1ns / 1ps
package bsq_pkg;

  // Frame geometry and pixel depth
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_WIDTH  = 640;
  localparam int PIXEL_BITS   = 8;

  // Field widths
  localparam int ROW_W         = 9;
  localparam int COL_W         = 10;
  localparam int FRAME_COUNT_W = 16;
  localparam int NOISE_W       = 16;
  localparam int SIZE_W        = 7;
  localparam int SHIFT_W       = 3;
  localparam int SKIP_W        = 8;
  localparam int PIXEL_W       = 8;

  // APB port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [PIXEL_BITS-1:0] FULL_SCALE = '1;
  localparam logic [ROW_W-1:0] LAST_SCAN_ROW = ROW_W'(FRAME_HEIGHT - 1);
  localparam logic [COL_W-1:0] LAST_SCAN_COL = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] BASE_ROW_RESET = ROW_W'(100);
  localparam logic [COL_W-1:0] BASE_COL_RESET = COL_W'(100);

  // Skip arithmetic: noise + pixels per frame * skip, reduced bit by bit
  localparam int FRAME_PIXELS = FRAME_HEIGHT * FRAME_WIDTH;
  localparam int SKIP_SUM_MAX = (1 << NOISE_W) - 1 + FRAME_PIXELS * ((1 << SKIP_W) - 1);
  localparam int SKIP_SUM_W   = $clog2(SKIP_SUM_MAX + 1);
  localparam int MOD_W        = NOISE_W + 1;
  localparam int BITCNT_W     = $clog2(SKIP_SUM_W + 1);

  typedef enum logic [2:0] {
    REG_BASE_FIRST_ROW = 3'd0,
    REG_BASE_LAST_ROW  = 3'd1,
    REG_BASE_FIRST_COL = 3'd2,
    REG_BASE_LAST_COL  = 3'd3,
    REG_SQUARE_SIZE    = 3'd4,
    REG_NOISE_PERIOD   = 3'd5,
    REG_DISTANCE_SHIFT = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [ROW_W-1:0]   base_first_row;
    logic [ROW_W-1:0]   base_last_row;
    logic [COL_W-1:0]   base_first_col;
    logic [COL_W-1:0]   base_last_col;
    logic [SIZE_W-1:0]  square_size;
    logic [NOISE_W-1:0] noise_period;
    logic [SHIFT_W-1:0] distance_shift;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic load_pixel;
    logic start_skip;
    logic move_step;
    logic mod_step;
    logic finish_skip;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic move_done;
    logic mod_done;
  } status_t;

endpackage

### hw/rtl/bsq_req_if.sv
`timescale 1ns / 1ps
interface bsq_req_if import bsq_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SKIP_W-1:0] skip_frames;

  modport source (output valid, kind, skip_frames, input ready);
  modport sink (input valid, kind, skip_frames, output ready);
endinterface

### hw/rtl/bsq_rsp_if.sv
`timescale 1ns / 1ps
interface bsq_rsp_if import bsq_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, pixel, input ready);
  modport sink (input valid, pixel, output ready);
endinterface

### hw/rtl/bsq_cfg_regs.sv
`timescale 1ns / 1ps
module bsq_cfg_regs import bsq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_first_row <= ROW_W'(0);
      cfg.base_last_row  <= ROW_W'(415);
      cfg.base_first_col <= COL_W'(0);
      cfg.base_last_col  <= COL_W'(575);
      cfg.square_size    <= SIZE_W'(32);
      cfg.noise_period   <= NOISE_W'(1021);
      cfg.distance_shift <= SHIFT_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_BASE_FIRST_ROW: cfg.base_first_row <= pwdata[ROW_W-1:0];
        REG_BASE_LAST_ROW:  cfg.base_last_row  <= pwdata[ROW_W-1:0];
        REG_BASE_FIRST_COL: cfg.base_first_col <= pwdata[COL_W-1:0];
        REG_BASE_LAST_COL:  cfg.base_last_col  <= pwdata[COL_W-1:0];
        REG_SQUARE_SIZE:    cfg.square_size    <= pwdata[SIZE_W-1:0];
        REG_NOISE_PERIOD:   cfg.noise_period   <= pwdata[NOISE_W-1:0];
        REG_DISTANCE_SHIFT: cfg.distance_shift <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_BASE_FIRST_ROW: prdata = APB_DATA_W'(cfg.base_first_row);
      REG_BASE_LAST_ROW:  prdata = APB_DATA_W'(cfg.base_last_row);
      REG_BASE_FIRST_COL: prdata = APB_DATA_W'(cfg.base_first_col);
      REG_BASE_LAST_COL:  prdata = APB_DATA_W'(cfg.base_last_col);
      REG_SQUARE_SIZE:    prdata = APB_DATA_W'(cfg.square_size);
      REG_NOISE_PERIOD:   prdata = APB_DATA_W'(cfg.noise_period);
      REG_DISTANCE_SHIFT: prdata = APB_DATA_W'(cfg.distance_shift);
      default:            prdata = '0;
    endcase
  end

endmodule

### hw/rtl/bsq_ctrl.sv
`timescale 1ns / 1ps
module bsq_ctrl import bsq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    req_kind,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid && status.out_free && req_kind) begin
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (status.move_done) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.mod_done && status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = status.out_free;
        if (req_valid && status.out_free) begin
          cmd.load_pixel = !req_kind;
          cmd.start_skip = req_kind;
        end
      end
      ST_MOVE: begin
        cmd.move_step = !status.move_done;
      end
      ST_MOD: begin
        cmd.mod_step    = !status.mod_done;
        cmd.finish_skip = status.mod_done && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/bsq_datapath.sv
`timescale 1ns / 1ps
`include "bouncing_square_test_pattern_top_defines.svh"
module bsq_datapath import bsq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  input  logic [SKIP_W-1:0]  req_skip,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [PIXEL_W-1:0] rsp_pixel,
  output status_t            status
);

  // Scan and pattern state
  logic [ROW_W-1:0]         scan_row;
  logic [COL_W-1:0]         scan_col;
  logic [ROW_W-1:0]         base_row;
  logic [COL_W-1:0]         base_col;
  logic                     row_step_down;
  logic                     col_step_down;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [NOISE_W-1:0]       noise_count;

  // Skip sequencing
  logic [SKIP_W-1:0]      skip_left;
  logic [SKIP_W-1:0]      skip_frames;
  logic [SKIP_SUM_W-1:0]  skip_sum;
  logic [NOISE_W-1:0]     rem;
  logic [MOD_W-1:0]       modulus;
  logic [BITCNT_W-1:0]    bit_left;

  // Returns {new direction, new position}; narrower axes pass zero-extended
  function automatic logic [COL_W:0] axis_step(input logic [COL_W-1:0] pos,
                                               input logic [COL_W-1:0] first,
                                               input logic [COL_W-1:0] last,
                                               input logic down);
    logic d;
    d = down;
    if (pos == last) begin
      d = 1'b1;
    end else if (pos == first) begin
      d = 1'b0;
    end
    return {d, d ? pos - COL_W'(1) : pos + COL_W'(1)};
  endfunction

  logic [COL_W:0]   row_stepped;
  logic [COL_W:0]   col_stepped;
  logic             row_ge;
  logic             col_ge;
  logic [ROW_W-1:0] dr;
  logic [COL_W-1:0] dc;
  logic             in_square;
  logic [COL_W-1:0] dist_max;
  logic [COL_W-1:0] dist_sh;
  logic [PIXEL_BITS:0] bright;
  logic [PIXEL_BITS-1:0] pix;
  logic             noise_hit;
  logic             frame_end;
  logic [MOD_W-1:0] rem_shift;
  logic [NOISE_W-1:0] rem_next;

  // Base step for frame ends and skip iterations
  assign row_stepped = axis_step(COL_W'(base_row), COL_W'(cfg.base_first_row),
                                 COL_W'(cfg.base_last_row), row_step_down);
  assign col_stepped = axis_step(base_col, cfg.base_first_col,
                                 cfg.base_last_col, col_step_down);

  // Square shading
  assign row_ge    = scan_row >= base_row;
  assign col_ge    = scan_col >= base_col;
  assign dr        = scan_row - base_row;
  assign dc        = scan_col - base_col;
  assign in_square = row_ge && col_ge && (dr < ROW_W'(cfg.square_size))
                     && (dc < COL_W'(cfg.square_size));
  assign dist_max  = (COL_W'(dr) > dc) ? COL_W'(dr) : dc;
  assign dist_sh   = dist_max >> cfg.distance_shift;
  assign bright    = {1'b0, ~dist_sh[PIXEL_BITS-1:0]}
                     + {1'b0, frame_count[3 +: PIXEL_BITS]};
  assign noise_hit = noise_count == NOISE_W'(cfg.noise_period - NOISE_W'(1));

  always_comb begin
    pix = '0;
    if (in_square) begin
      pix = bright[PIXEL_BITS] ? FULL_SCALE : bright[PIXEL_BITS-1:0];
    end
    if (noise_hit) begin
      pix = FULL_SCALE;
    end
  end

  assign frame_end = (scan_col == LAST_SCAN_COL) && (scan_row == LAST_SCAN_ROW);

  // One restoring remainder step
  assign rem_shift = {rem, skip_sum[SKIP_SUM_W-1]};
  assign rem_next  = (rem_shift >= modulus) ? NOISE_W'(rem_shift - modulus)
                                            : NOISE_W'(rem_shift);

  // Advance scan, base and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row      <= '0;
      scan_col      <= '0;
      base_row      <= BASE_ROW_RESET;
      base_col      <= BASE_COL_RESET;
      row_step_down <= 1'b0;
      col_step_down <= 1'b0;
      frame_count   <= '0;
      noise_count   <= '0;
    end else begin
      if (cmd.load_pixel) begin
        if (scan_col == LAST_SCAN_COL) begin
          scan_col <= '0;
          if (scan_row == LAST_SCAN_ROW) begin
            scan_row <= '0;
          end else begin
            scan_row <= scan_row + ROW_W'(1);
          end
        end else begin
          scan_col <= scan_col + COL_W'(1);
        end
        if (frame_end) begin
          frame_count <= frame_count + FRAME_COUNT_W'(1);
        end
        noise_count <= noise_hit ? '0 : noise_count + NOISE_W'(1);
      end
      if ((cmd.load_pixel && frame_end) || cmd.move_step) begin
        row_step_down <= row_stepped[COL_W];
        base_row      <= row_stepped[ROW_W-1:0];
        col_step_down <= col_stepped[COL_W];
        base_col      <= col_stepped[COL_W-1:0];
      end
      if (cmd.finish_skip) begin
        noise_count <= rem;
        frame_count <= frame_count + FRAME_COUNT_W'(skip_frames);
      end
    end
  end

  // Skip counters
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left <= '0;
      bit_left  <= '0;
    end else if (cmd.start_skip) begin
      skip_left <= req_skip;
      bit_left  <= BITCNT_W'(SKIP_SUM_W);
    end else begin
      if (cmd.move_step) begin
        skip_left <= skip_left - SKIP_W'(1);
      end
      if (cmd.mod_step) begin
        bit_left <= bit_left - BITCNT_W'(1);
      end
    end
  end

  // Skip operands and remainder
  always_ff @(posedge clk) begin
    if (cmd.start_skip) begin
      skip_frames <= req_skip;
      skip_sum    <= SKIP_SUM_W'(noise_count)
                     + SKIP_SUM_W'(FRAME_PIXELS) * SKIP_SUM_W'(req_skip);
      rem         <= '0;
      modulus     <= (cfg.noise_period == '0) ? MOD_W'(1 << NOISE_W)
                                              : MOD_W'(cfg.noise_period);
    end else if (cmd.mod_step) begin
      skip_sum <= skip_sum << 1;
      rem      <= rem_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_pixel || cmd.finish_skip) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      rsp_pixel <= PIXEL_W'(pix);
    end else if (cmd.finish_skip) begin
      rsp_pixel <= '0;
    end
  end

  assign status.out_free  = !rsp_valid || rsp_ready;
  assign status.move_done = skip_left == '0;
  assign status.mod_done  = bit_left == '0;

  `BSQ_ASSERT_IMPL(a_load_needs_room, cmd.load_pixel || cmd.finish_skip, status.out_free)
  `BSQ_ASSERT_IMPL(a_move_in_range, cmd.move_step, skip_left != '0)
  `BSQ_ASSERT_IMPL(a_mod_in_range, cmd.mod_step, bit_left != '0)
  `BSQ_ASSERT_NEXT(a_noise_reduced, cmd.finish_skip, MOD_W'(noise_count) < modulus)

endmodule

### hw/rtl/bouncing_square_test_pattern_top.sv
`timescale 1ns / 1ps
// Bouncing square test pattern generator.
// req channel: kind 0 asks for the next raster pixel, kind 1 skips
// skip_frames whole frames ahead. rsp channel: one pixel per request,
// 0 for skips. An item transfers when valid and ready are both high.
// Pixel requests: the result is registered in the cycle after the transfer;
// one pixel per cycle while rsp is taken, shaded by a combinational path.
// Skip requests: the base is stepped once per skipped frame, then the noise
// counter is reduced by restoring division, one remainder bit per cycle.
// No request is taken while a skip is in progress.
// The APB port holds the seven registers at byte address 4*index; writes
// complete in the access cycle, pready is tied high.
// Reset (rst, synchronous) restores register defaults, scan at the top-left,
// base at row 100 column 100 moving up the axes, and clears both counters.
// When rsp stalls the finished pixel is held in the output register and req
// stays ready only if that pixel leaves in the same cycle.
module bouncing_square_test_pattern_top import bsq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bsq_req_if.sink               req,
  bsq_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    req_ready;
  logic    rsp_valid;
  logic [PIXEL_W-1:0] rsp_pixel;

  bsq_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bsq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .req_skip  (req.skip_frames),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp_valid),
    .rsp_pixel (rsp_pixel),
    .status    (status)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.pixel = rsp_pixel;

endmodule

### test/bouncing_square_test_pattern_top_tb.sv
`timescale 1ns / 1ps
module bouncing_square_test_pattern_top_tb;
  import bsq_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_SKIP  = 1'b1;
  localparam int   MAX_REPORTS = 50;
  localparam int   LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic              kind;
    logic [SKIP_W-1:0] skip_frames;
  } pattern_req_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  bsq_req_if req_ch ();
  bsq_rsp_if rsp_ch ();

  bouncing_square_test_pattern_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the pattern generator: registers, raster position, square, counters
  cfg_t               regs;
  logic [ROW_W-1:0]   ras_row = '0;
  logic [COL_W-1:0]   ras_col = '0;
  logic [ROW_W-1:0]   sq_row = BASE_ROW_RESET;
  logic [COL_W-1:0]   sq_col = BASE_COL_RESET;
  logic               sq_row_down = 1'b0;
  logic               sq_col_down = 1'b0;
  logic [FRAME_COUNT_W-1:0] sq_frames = '0;
  logic [NOISE_W-1:0] noise_run = '0;

  pattern_req_t       pending_reqs[$];
  logic [PIXEL_W-1:0] expected_pixels[$];
  int                 mismatches = 0;

  // Traffic shaping knobs, set per phase
  int gap_max = 0;
  int stall_max = 0;
  int long_holds = 0;

  // Driver and receiver private state
  int   burst_left = 0;
  int   gap_left = 0;
  logic offer;
  logic accepted;
  int   holds_served = 0;
  int   hold_left = 0;
  int   rx_left = 0;
  logic rx_stall = 1'b0;
  logic [PIXEL_W-1:0] want;

  // Move the square base one frame step on both axes, last bound checked first
  function automatic void bounce_square();
    if (sq_row == regs.base_last_row) sq_row_down = 1'b1;
    else if (sq_row == regs.base_first_row) sq_row_down = 1'b0;
    sq_row = sq_row_down ? sq_row - ROW_W'(1) : sq_row + ROW_W'(1);
    if (sq_col == regs.base_last_col) sq_col_down = 1'b1;
    else if (sq_col == regs.base_first_col) sq_col_down = 1'b0;
    sq_col = sq_col_down ? sq_col - COL_W'(1) : sq_col + COL_W'(1);
  endfunction

  // Compute the pixel for one request and advance the shadow state
  function automatic logic [PIXEL_W-1:0] next_pixel(pattern_req_t r);
    int unsigned dr;
    int unsigned dc;
    int unsigned dist_max;
    int unsigned sum;
    longint unsigned span;
    logic [NOISE_W-1:0] noise_last;
    logic [PIXEL_W-1:0] pix;
    logic noise_hit;
    if (r.kind == KIND_SKIP) begin
      repeat (r.skip_frames) bounce_square();
      span = (regs.noise_period == '0) ? 64'd65536 : 64'(regs.noise_period);
      noise_run = NOISE_W'((64'(noise_run) + 64'(FRAME_PIXELS) * 64'(r.skip_frames)) % span);
      sq_frames = sq_frames + FRAME_COUNT_W'(r.skip_frames);
      return '0;
    end
    // shade inside the square only, no wrap around the frame edge
    pix = '0;
    if (ras_row >= sq_row && ras_col >= sq_col) begin
      dr = 32'(ras_row - sq_row);
      dc = 32'(ras_col - sq_col);
      if (dr < 32'(regs.square_size) && dc < 32'(regs.square_size)) begin
        dist_max = ((dr > dc) ? dr : dc) >> regs.distance_shift;
        sum = (~dist_max & 32'(FULL_SCALE)) + ((32'(sq_frames) >> 3) & 32'(FULL_SCALE));
        pix = (sum > 32'(FULL_SCALE)) ? FULL_SCALE : PIXEL_W'(sum);
      end
    end
    noise_last = regs.noise_period - NOISE_W'(1);
    noise_hit = (noise_run == noise_last);
    if (noise_hit) pix = FULL_SCALE;
    // advance the raster; a frame end moves the square
    if (ras_col == LAST_SCAN_COL) begin
      ras_col = '0;
      if (ras_row == LAST_SCAN_ROW) begin
        ras_row = '0;
        bounce_square();
        sq_frames = sq_frames + FRAME_COUNT_W'(1);
      end else begin
        ras_row = ras_row + ROW_W'(1);
      end
    end else begin
      ras_col = ras_col + COL_W'(1);
    end
    noise_run = noise_hit ? '0 : noise_run + NOISE_W'(1);
    return pix;
  endfunction

  function automatic void queue_req(logic kind, logic [SKIP_W-1:0] frames);
    pattern_req_t r;
    r.kind = kind;
    r.skip_frames = frames;
    pending_reqs.push_back(r);
  endfunction

  // Mostly pixels with random content, a few skips including the extremes
  function automatic void queue_random_reqs(int n);
    logic [SKIP_W-1:0] frames;
    for (int i = 0; i < n; i++) begin
      frames = SKIP_W'($urandom);
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 5))
          0: frames = '0;
          1: frames = '1;
          default: ;
        endcase
        queue_req(KIND_SKIP, frames);
      end else begin
        queue_req(KIND_PIXEL, frames);
      end
    end
  endfunction

  // Pick bounds that keep the square near the top rows most of the time
  function automatic cfg_t random_setup();
    cfg_t s;
    s.base_first_row = ROW_W'($urandom_range(0, 2));
    s.base_last_row  = s.base_first_row + ROW_W'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      s.base_first_row = ROW_W'($urandom);
      s.base_last_row  = ROW_W'($urandom);
    end
    s.base_first_col = COL_W'($urandom_range(0, 600));
    s.base_last_col  = s.base_first_col + COL_W'($urandom_range(0, 40));
    if ($urandom_range(0, 4) == 0) begin
      s.base_first_col = '0;
      s.base_last_col  = '1;
    end
    case ($urandom_range(0, 5))
      0: s.square_size = SIZE_W'(1);
      1: s.square_size = SIZE_W'(64);
      2: s.square_size = '1;
      3: s.square_size = '0;
      default: s.square_size = SIZE_W'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 5))
      0: s.noise_period = '0;
      1: s.noise_period = NOISE_W'(1);
      2: s.noise_period = '1;
      3: s.noise_period = NOISE_W'($urandom);
      default: s.noise_period = NOISE_W'($urandom_range(1, 40));
    endcase
    s.distance_shift = SHIFT_W'($urandom_range(0, 7));
    return s;
  endfunction

  // One APB write: setup cycle, then access until pready; read the value back
  task automatic write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE_FIRST_ROW: regs.base_first_row = value[ROW_W-1:0];
      REG_BASE_LAST_ROW:  regs.base_last_row  = value[ROW_W-1:0];
      REG_BASE_FIRST_COL: regs.base_first_col = value[COL_W-1:0];
      REG_BASE_LAST_COL:  regs.base_last_col  = value[COL_W-1:0];
      REG_SQUARE_SIZE:    regs.square_size    = value[SIZE_W-1:0];
      REG_NOISE_PERIOD:   regs.noise_period   = value[NOISE_W-1:0];
      REG_DISTANCE_SHIFT: regs.distance_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
    case (idx)
      REG_BASE_FIRST_ROW: readback = APB_DATA_W'(regs.base_first_row);
      REG_BASE_LAST_ROW:  readback = APB_DATA_W'(regs.base_last_row);
      REG_BASE_FIRST_COL: readback = APB_DATA_W'(regs.base_first_col);
      REG_BASE_LAST_COL:  readback = APB_DATA_W'(regs.base_last_col);
      REG_SQUARE_SIZE:    readback = APB_DATA_W'(regs.square_size);
      REG_NOISE_PERIOD:   readback = APB_DATA_W'(regs.noise_period);
      REG_DISTANCE_SHIFT: readback = APB_DATA_W'(regs.distance_shift);
      default:            readback = '0;
    endcase
    // paddr still points at the register just written
    @(posedge clk);
    if (prdata !== readback) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", idx.name(), readback, prdata);
    end
  endtask

  task automatic load_setup(cfg_t s);
    write_reg(REG_BASE_FIRST_ROW, APB_DATA_W'(s.base_first_row));
    write_reg(REG_BASE_LAST_ROW,  APB_DATA_W'(s.base_last_row));
    write_reg(REG_BASE_FIRST_COL, APB_DATA_W'(s.base_first_col));
    write_reg(REG_BASE_LAST_COL,  APB_DATA_W'(s.base_last_col));
    write_reg(REG_SQUARE_SIZE,    APB_DATA_W'(s.square_size));
    write_reg(REG_NOISE_PERIOD,   APB_DATA_W'(s.noise_period));
    write_reg(REG_DISTANCE_SHIFT, APB_DATA_W'(s.distance_shift));
  endtask

  // Wait for every queued request to transfer and every pixel to come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_pixels.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer queued requests in bursts; predict the pixel on each transfer
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      offer = 1'b0;
      accepted = req_ch.valid && req_ch.ready;
      if (accepted) expected_pixels.push_back(next_pixel(pending_reqs.pop_front()));
      if (req_ch.valid && !accepted) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        offer = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 32);
        burst_left--;
        if (burst_left == 0 && gap_max > 0) gap_left = $urandom_range(0, gap_max);
      end
      req_ch.valid <= offer;
      if (offer) begin
        req_ch.kind        <= pending_reqs[0].kind;
        req_ch.skip_frames <= pending_reqs[0].skip_frames;
      end
    end
  end

  // Check each pixel transfer and drive ready on its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("pixel %0d transferred with no request outstanding", rsp_ch.pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (rsp_ch.pixel !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $error("pixel: expected %0d, got %0d", want, rsp_ch.pixel);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (holds_served != long_holds) begin
        // hold off long enough to back up the request side
        holds_served = long_holds;
        hold_left = LONG_HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          if (stall_max > 0 && $urandom_range(0, 2) == 0) begin
            rx_stall = 1'b1;
            rx_left = $urandom_range(1, stall_max);
          end else begin
            rx_stall = 1'b0;
            rx_left = $urandom_range(1, 24);
          end
        end
        rx_left--;
        rsp_ch.ready <= !rx_stall;
      end
    end
  end

  // Bound the run
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    int added;
    int n;
    cfg_t s;
    regs = '{9'd0, 9'd415, 10'd0, 10'd575, 7'd32, 16'd1021, 3'd1};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_PIXEL;
    req_ch.skip_frames = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: pixels ignore the skip field, a zero-frame skip is a no-op
    gap_max = 4;
    stall_max = 4;
    queue_req(KIND_PIXEL, '1);
    queue_req(KIND_PIXEL, '0);
    queue_req(KIND_PIXEL, 8'h5A);
    queue_req(KIND_SKIP, '0);
    queue_req(KIND_PIXEL, 8'hA5);
    wait_drained();

    // Every register at its top value
    load_setup('{'1, '1, '1, '1, '1, '1, '1});
    queue_req(KIND_SKIP, '1);
    queue_req(KIND_PIXEL, '0);
    queue_req(KIND_PIXEL, '1);
    wait_drained();

    // Every register cleared: no square, noise interval wraps to 65536
    load_setup('0);
    queue_req(KIND_SKIP, 8'd1);
    queue_req(KIND_PIXEL, '0);
    queue_req(KIND_PIXEL, '0);
    queue_req(KIND_SKIP, '1);
    wait_drained();

    // Noise period of one: noise on every pixel once the noise counter is at zero
    load_setup('{9'd0, 9'd1, 10'd0, 10'd1000, 7'd64, 16'd1, 3'd0});
    queue_req(KIND_PIXEL, '0);
    queue_req(KIND_PIXEL, '1);
    wait_drained();

    // Pull the square to the top rows and brighten it
    load_setup('{9'd0, 9'd3, 10'd0, 10'd40, 7'd64, 16'd3, 3'd0});
    queue_req(KIND_SKIP, '1);
    queue_req(KIND_SKIP, '1);
    repeat (4) queue_req(KIND_PIXEL, '0);
    wait_drained();

    // Random phases; the first one backs up behind a long receiver hold
    for (int p = 0; p < 6; p++) begin
      s = random_setup();
      load_setup(s);
      gap_max = (p % 3 == 0) ? 0 : 8;
      stall_max = (p % 3 == 0) ? 0 : 6;
      queue_random_reqs(240);
      if (p == 0) long_holds++;
      wait_drained();
    end

    // Drive the frame counter past its wrap with large skips
    load_setup('{9'd0, 9'd2, 10'd0, 10'd639, 7'd64, 16'd1021, 3'd2});
    gap_max = 3;
    stall_max = 3;
    added = 0;
    while (added < 70000) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_req(KIND_PIXEL, SKIP_W'($urandom));
      end else begin
        n = $urandom_range(192, 255);
        queue_req(KIND_SKIP, SKIP_W'(n));
        added += n;
      end
    end
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bsq_pkg.sv
hw/rtl/bsq_req_if.sv
hw/rtl/bsq_rsp_if.sv
hw/rtl/bsq_cfg_regs.sv
hw/rtl/bsq_ctrl.sv
hw/rtl/bsq_datapath.sv
hw/rtl/bouncing_square_test_pattern_top.sv
test/bouncing_square_test_pattern_top_tb.sv
